>>> src/smpg_pkg.sv
// ----------------------------------------------------------------------------
// smpg_pkg
// Shared types and constants for the source mask prune and grow block.
// ----------------------------------------------------------------------------
`default_nettype none
package smpg_pkg;

   localparam int unsigned DefMaxWidth  = 256;
   localparam int unsigned DefMaxHeight = 256;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_PROCESS = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;

   localparam logic [2:0] CSR_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_SRCBIT = 3'd2;
   localparam logic [2:0] CSR_MINNB  = 3'd3;
   localparam logic [2:0] CSR_GROW   = 3'd4;

   localparam int unsigned CsrDataWidth = 9;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] pixel_index;
      logic [15:0] quality_word;
   } req_type;

   typedef struct packed {
      logic [15:0] read_word;
      logic        pass_done;
   } rsp_type;

   // pass phases: mark survivors, grow, write back
   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_PRUNE = 4'b0010,
      PH_GROW  = 4'b0100,
      PH_APPLY = 4'b1000
   } phase_type;

endpackage
`default_nettype wire

>>> src/source_mask_prune_and_grow.sv
// ----------------------------------------------------------------------------
// source_mask_prune_and_grow
// Frame store with a source flag prune (3x3 count) and grow (cross or 3x3).
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low. A load item
// writes one word of the frame memory, a read item returns one word, a
// process item runs the pass. Each item gives one result on rsp_item with
// rsp_valid high for exactly one cycle; the receiver cannot stall.
// Load and read: the result is registered in v1_ff and the frame RAM read,
// then in the output register; one item per cycle while busy is low.
// Process: three sweeps over the frame in use, one memory read per cycle:
// prune and grow visit all nine window places of each pixel, the write
// back visits each pixel once; busy meanwhile.
// Survivor and grow masks are one bit RAMs; every entry in use is written
// in its sweep, so they need no clearing pass. The grow sweep gathers the
// grow bit as the OR of survivors in the window, which is the same mask.
// Reset clears the control state and loads register reset values; frame
// contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none
module source_mask_prune_and_grow #(
   parameter int unsigned MAX_WIDTH  = smpg_pkg::DefMaxWidth,
   parameter int unsigned MAX_HEIGHT = smpg_pkg::DefMaxHeight
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire smpg_pkg::req_type                     req_item,
   output logic                                       rsp_valid,
   output smpg_pkg::rsp_type                          rsp_item,
   input  wire logic                                  csr_we,
   input  wire logic [2:0]                            csr_index,
   input  wire logic [smpg_pkg::CsrDataWidth-1:0]     csr_wdata
);
   localparam int unsigned XW    = $clog2(MAX_WIDTH);
   localparam int unsigned YW    = $clog2(MAX_HEIGHT);
   localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned AW    = $clog2(DEPTH);

   // configuration registers
   logic [8:0] width_ff, height_ff;
   logic [3:0] srcbit_ff, minnb_ff;
   logic       grow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
         srcbit_ff <= 4'd11;
         minnb_ff  <= 4'd4;
         grow_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            smpg_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[8:0];
            smpg_pkg::CSR_HEIGHT: height_ff <= csr_wdata[8:0];
            smpg_pkg::CSR_SRCBIT: srcbit_ff <= csr_wdata[3:0];
            smpg_pkg::CSR_MINNB:  minnb_ff  <= csr_wdata[3:0];
            smpg_pkg::CSR_GROW:   grow_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // clamped dimensions
   logic [XW:0] w;
   logic [YW:0] h;
   always_comb begin
      if (width_ff == 9'd0) w = (XW+1)'(1);
      else if (32'(width_ff) > MAX_WIDTH) w = (XW+1)'(MAX_WIDTH);
      else w = (XW+1)'(width_ff);
      if (height_ff == 9'd0) h = (YW+1)'(1);
      else if (32'(height_ff) > MAX_HEIGHT) h = (YW+1)'(MAX_HEIGHT);
      else h = (YW+1)'(height_ff);
   end

   // sequencer
   smpg_pkg::phase_type phase;
   logic [XW-1:0] px, nx;
   logic [YW-1:0] py, ny;
   logic [3:0]    tap;
   logic          tap_ok, last_tap, seq_done;
   logic          accept;

   assign accept = start && !busy;

   smpg_seq #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_seq (
      .clock, .reset,
      .go       (accept && req_item.operation == smpg_pkg::OP_PROCESS),
      .w, .h, .phase, .px, .py, .tap, .tap_ok, .nx, .ny, .last_tap,
      .done     (seq_done)
   );

   // row-major addresses using the width in use
   logic [AW-1:0] n_addr, p_addr;
   assign n_addr = AW'(32'(ny) * 32'(w) + 32'(nx));
   assign p_addr = AW'(32'(py) * 32'(w) + 32'(px));

   // pipeline stage that registers the sequencer outputs
   smpg_pkg::phase_type ph_d_ff;
   logic          ok_d_ff, last_d_ff, center_d_ff, cross_d_ff, done_d_ff;
   logic [AW-1:0] paddr_d_ff;
   logic [3:0]    count_ff, count_in;
   logic          any_ff, any_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_d_ff   <= smpg_pkg::PH_IDLE;
         done_d_ff <= 1'b0;
      end else begin
         ph_d_ff   <= phase;
         done_d_ff <= seq_done;
      end
      ok_d_ff     <= tap_ok;
      last_d_ff   <= last_tap;
      center_d_ff <= (tap == 4'd4);
      cross_d_ff  <= (tap == 4'd1) || (tap == 4'd3) || (tap == 4'd4) ||
                     (tap == 4'd5) || (tap == 4'd7);
      paddr_d_ff  <= p_addr;
   end

   // memories
   logic          fr_we, sv_we, gr_we;
   logic [AW-1:0] fr_waddr, fr_raddr;
   logic [15:0]   fr_wdata, fr_rdata;
   logic          sv_wdata, sv_rdata, gr_wdata, gr_rdata;
   logic          gr_fwd_ff, gr_fwd_bit_ff, gr_bit;
   logic [15:0]   flag;
   logic          hit;

   assign flag = 16'(1) << srcbit_ff;
   assign hit  = (fr_rdata & flag) != 16'd0;

   assign fr_raddr = (phase == smpg_pkg::PH_PRUNE) ? n_addr :
                     (phase == smpg_pkg::PH_APPLY) ? p_addr :
                     AW'(req_item.pixel_index);

   smpg_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_frame (
      .clock, .wr_en(fr_we), .wr_addr(fr_waddr), .wr_data(fr_wdata),
      .rd_addr(fr_raddr), .rd_data(fr_rdata)
   );
   smpg_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_surv (
      .clock, .wr_en(sv_we), .wr_addr(paddr_d_ff), .wr_data(sv_wdata),
      .rd_addr(n_addr), .rd_data(sv_rdata)
   );
   smpg_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_grow (
      .clock, .wr_en(gr_we), .wr_addr(paddr_d_ff), .wr_data(gr_wdata),
      .rd_addr(p_addr), .rd_data(gr_rdata)
   );

   // forward a grow bit written in the cycle of its read (single pixel frame)
   always_ff @(posedge clock) begin
      gr_fwd_ff     <= gr_we && (paddr_d_ff == p_addr);
      gr_fwd_bit_ff <= gr_wdata;
   end
   assign gr_bit = gr_fwd_ff ? gr_fwd_bit_ff : gr_rdata;

   // window accumulation and write back
   logic in_range;
   assign in_range = 32'(req_item.pixel_index) < DEPTH;

   always_comb begin
      count_in = count_ff;
      any_in   = any_ff;
      sv_we    = 1'b0;
      sv_wdata = 1'b0;
      gr_we    = 1'b0;
      gr_wdata = 1'b0;
      fr_we    = accept && req_item.operation == smpg_pkg::OP_LOAD && in_range;
      fr_waddr = AW'(req_item.pixel_index);
      fr_wdata = req_item.quality_word;
      case (ph_d_ff)
         smpg_pkg::PH_PRUNE: begin
            if (ok_d_ff && hit) count_in = count_ff + 4'd1;
            if (center_d_ff) any_in = hit;
            if (last_d_ff) begin
               sv_we    = 1'b1;
               sv_wdata = any_in && (count_in >= minnb_ff);
               count_in = '0;
               any_in   = 1'b0;
            end
         end
         smpg_pkg::PH_GROW: begin
            if (ok_d_ff && sv_rdata && (grow_ff || cross_d_ff)) any_in = 1'b1;
            if (last_d_ff) begin
               gr_we    = 1'b1;
               gr_wdata = any_in;
               any_in   = 1'b0;
            end
         end
         smpg_pkg::PH_APPLY: begin
            fr_we    = 1'b1;
            fr_waddr = paddr_d_ff;
            fr_wdata = gr_bit ? (fr_rdata | flag) : (fr_rdata & ~flag);
         end
         default: begin
            count_in = '0;
            any_in   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         any_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         any_ff   <= any_in;
      end
   end

   // busy from item accept of a pass until its result has gone out
   logic pass_ff;
   always_ff @(posedge clock) begin
      if (reset) pass_ff <= 1'b0;
      else if (accept && req_item.operation == smpg_pkg::OP_PROCESS) pass_ff <= 1'b1;
      else if (done_d_ff) pass_ff <= 1'b0;
   end
   assign busy = pass_ff;

   // load and read result pipeline
   logic       v1_ff, rd1_ff, rdok1_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept && req_item.operation != smpg_pkg::OP_PROCESS;
      end
      rd1_ff   <= req_item.operation == smpg_pkg::OP_READ;
      rdok1_ff <= in_range;
   end

   // result output
   logic              rsp_v_ff;
   smpg_pkg::rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_v_ff <= 1'b0;
      else       rsp_v_ff <= v1_ff || done_d_ff;
      rsp_ff.read_word <= (v1_ff && rd1_ff && rdok1_ff) ? fr_rdata : 16'd0;
      rsp_ff.pass_done <= done_d_ff;
   end
   assign rsp_valid = rsp_v_ff;
   assign rsp_item  = rsp_ff;

   // checks
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      done_d_ff |-> pass_ff)
      else $error("pass finished while not busy");
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      done_d_ff |=> rsp_valid && rsp_item.pass_done)
      else $error("pass done without result");
   a_no_idle_walk: assert property (@(posedge clock) disable iff (reset)
      !pass_ff |-> phase == smpg_pkg::PH_IDLE)
      else $error("sequencer running while idle");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> !done_d_ff)
      else $error("two results in one cycle");
endmodule
`default_nettype wire

>>> src/smpg_ram.sv
// ----------------------------------------------------------------------------
// smpg_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module smpg_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> src/smpg_seq.sv
// ----------------------------------------------------------------------------
// smpg_seq
// Pass sequencer: walks the frame once per phase (all window places in prune
// and grow). Each step issues one memory read; the datapath uses it next cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module smpg_seq #(
   parameter int unsigned MAX_WIDTH  = smpg_pkg::DefMaxWidth,
   parameter int unsigned MAX_HEIGHT = smpg_pkg::DefMaxHeight
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          go,
   input  wire logic [$clog2(MAX_WIDTH):0]    w,
   input  wire logic [$clog2(MAX_HEIGHT):0]   h,
   output smpg_pkg::phase_type                phase,
   output logic      [$clog2(MAX_WIDTH)-1:0]  px,
   output logic      [$clog2(MAX_HEIGHT)-1:0] py,
   output logic      [3:0]                    tap,
   output logic                               tap_ok,
   output logic      [$clog2(MAX_WIDTH)-1:0]  nx,
   output logic      [$clog2(MAX_HEIGHT)-1:0] ny,
   output logic                               last_tap,
   output logic                               done
);
   localparam int unsigned XW = $clog2(MAX_WIDTH);
   localparam int unsigned YW = $clog2(MAX_HEIGHT);

   smpg_pkg::phase_type phase_ff, phase_in;
   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic [3:0]    tap_ff, tap_in;
   logic [1:0]    tcol, trow;
   logic [XW+1:0] sx;
   logic [YW+1:0] sy;
   logic          last_px, tap_end;

   assign phase = phase_ff;
   assign px    = x_ff;
   assign py    = y_ff;
   assign tap   = tap_ff;

   // window column and row of this tap
   always_comb begin
      case (tap_ff) inside
         4'd0, 4'd3, 4'd6: tcol = 2'd0;
         4'd1, 4'd4, 4'd7: tcol = 2'd1;
         default:          tcol = 2'd2;
      endcase
      case (tap_ff) inside
         [4'd0:4'd2]: trow = 2'd0;
         [4'd3:4'd5]: trow = 2'd1;
         default:     trow = 2'd2;
      endcase
   end

   // neighbor place for this tap; taps 0..8 cover the 3x3 window
   always_comb begin
      sx = {2'b00, x_ff} + {{(XW){1'b0}}, tcol} - (XW+2)'(1);
      sy = {2'b00, y_ff} + {{(YW){1'b0}}, trow} - (YW+2)'(1);
      tap_ok = !sx[XW+1] && !sy[YW+1] && (sx[XW:0] < w) && (sy[YW:0] < h);
      nx = sx[XW-1:0];
      ny = sy[YW-1:0];
   end

   assign tap_end  = (phase_ff == smpg_pkg::PH_APPLY) || (tap_ff == 4'd8);
   assign last_tap = tap_end;
   assign last_px  = ({1'b0, x_ff} == w - 1'b1) && ({1'b0, y_ff} == h - 1'b1);
   assign done     = (phase_ff == smpg_pkg::PH_APPLY) && last_px;

   // walk taps, then columns, then rows, then phases
   always_comb begin
      phase_in = phase_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      tap_in   = tap_ff;
      case (phase_ff)
         smpg_pkg::PH_IDLE: begin
            x_in = '0; y_in = '0; tap_in = '0;
            if (go) phase_in = smpg_pkg::PH_PRUNE;
         end
         smpg_pkg::PH_PRUNE, smpg_pkg::PH_GROW, smpg_pkg::PH_APPLY: begin
            if (!tap_end) begin
               tap_in = tap_ff + 4'd1;
            end else begin
               tap_in = '0;
               if ({1'b0, x_ff} != w - 1'b1) begin
                  x_in = x_ff + 1'b1;
               end else begin
                  x_in = '0;
                  if ({1'b0, y_ff} != h - 1'b1) begin
                     y_in = y_ff + 1'b1;
                  end else begin
                     y_in = '0;
                     case (phase_ff)
                        smpg_pkg::PH_PRUNE: phase_in = smpg_pkg::PH_GROW;
                        smpg_pkg::PH_GROW:  phase_in = smpg_pkg::PH_APPLY;
                        default:            phase_in = smpg_pkg::PH_IDLE;
                     endcase
                  end
               end
            end
         end
         default: phase_in = smpg_pkg::PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= smpg_pkg::PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      tap_ff <= tap_in;
   end
endmodule
`default_nettype wire

>>> tb/source_mask_prune_and_grow_tb.sv
// ----------------------------------------------------------------------------
// source_mask_prune_and_grow_tb
// Loads, reads and prune/grow passes under several register settings.
// Results are predicted by a behavioral frame model and checked in order.
// ----------------------------------------------------------------------------
`default_nettype none
module source_mask_prune_and_grow_tb;

   timeunit 1ns;
   timeprecision 1ps;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   smpg_pkg::req_type       req_item = '0;
   logic                    rsp_valid;
   smpg_pkg::rsp_type       rsp_item;
   logic                    csr_we = 1'b0;
   logic [2:0]              csr_index = smpg_pkg::CSR_WIDTH;
   logic [smpg_pkg::CsrDataWidth-1:0] csr_wdata = '0;

   source_mask_prune_and_grow DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // frame model and its registers
   logic [15:0] frame_words [65536];
   bit          survivors [65536];
   bit          grown [65536];
   logic [8:0]  reg_width = 9'd256;
   logic [8:0]  reg_height = 9'd256;
   logic [3:0]  reg_srcbit = 4'd11;
   logic [3:0]  reg_minnb = 4'd4;
   logic        reg_grow = 1'b0;

   smpg_pkg::req_type pending_items [$];
   smpg_pkg::rsp_type expected_rsps [$];
   bit          written [65536];
   int          errors = 0;
   logic        took = 1'b0;
   bit          steady = 0;

   function automatic int unsigned clamp_dim(logic [8:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return v;
   endfunction

   // prune by 3x3 count, grow by cross or 3x3, then rewrite the flag
   function automatic void prune_and_grow();
      int unsigned w, h, cnt;
      int          x, y, dx, dy, xx, yy;
      w = clamp_dim(reg_width);
      h = clamp_dim(reg_height);
      for (int k = 0; k < 65536; k++) begin
         survivors[k] = 0;
         grown[k] = 0;
      end
      for (y = 0; y < h; y++)
         for (x = 0; x < w; x++) begin
            if (frame_words[y*w+x][reg_srcbit]) begin
               cnt = 0;
               for (dy = -1; dy <= 1; dy++)
                  for (dx = -1; dx <= 1; dx++) begin
                     yy = y + dy;
                     xx = x + dx;
                     if (yy >= 0 && yy < h && xx >= 0 && xx < w)
                        if (frame_words[yy*w+xx][reg_srcbit]) cnt++;
                  end
               if (cnt >= reg_minnb) survivors[y*w+x] = 1;
            end
         end
      for (y = 0; y < h; y++)
         for (x = 0; x < w; x++)
            if (survivors[y*w+x])
               for (dy = -1; dy <= 1; dy++)
                  for (dx = -1; dx <= 1; dx++) begin
                     yy = y + dy;
                     xx = x + dx;
                     if (yy >= 0 && yy < h && xx >= 0 && xx < w &&
                         (reg_grow || dx == 0 || dy == 0))
                        grown[yy*w+xx] = 1;
                  end
      for (int k = 0; k < w*h; k++)
         frame_words[k][reg_srcbit] = grown[k];
   endfunction

   function automatic smpg_pkg::rsp_type frame_step(smpg_pkg::req_type it);
      smpg_pkg::rsp_type r;
      r = '0;
      case (it.operation)
         smpg_pkg::OP_LOAD:    frame_words[it.pixel_index] = it.quality_word;
         smpg_pkg::OP_PROCESS: begin
            prune_and_grow();
            r.pass_done = 1'b1;
         end
         smpg_pkg::OP_READ:    r.read_word = frame_words[it.pixel_index];
         default:    ;
      endcase
      return r;
   endfunction

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // driver: new item at the falling edge once the last one was taken
   always @(negedge clock) begin
      if (!reset && (!start || took)) begin
         if (pending_items.size() != 0 && (steady || $urandom_range(0, 99) >= 34)) begin
            req_item <= pending_items.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check results, track registers, predict accepted items
   always @(posedge clock) begin
      smpg_pkg::rsp_type exp_r;
      if (reset) begin
         took <= 1'b0;
      end else begin
         took <= start && !busy;
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result read_word=%h pass_done=%b",
                        $time, rsp_item.read_word, rsp_item.pass_done);
               errors++;
            end else begin
               exp_r = expected_rsps.pop_front();
               if (rsp_item.read_word !== exp_r.read_word) begin
                  $display("%0t: read_word expected %h actual %h",
                           $time, exp_r.read_word, rsp_item.read_word);
                  errors++;
               end
               if (rsp_item.pass_done !== exp_r.pass_done) begin
                  $display("%0t: pass_done expected %b actual %b",
                           $time, exp_r.pass_done, rsp_item.pass_done);
                  errors++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               smpg_pkg::CSR_WIDTH:  reg_width = csr_wdata;
               smpg_pkg::CSR_HEIGHT: reg_height = csr_wdata;
               smpg_pkg::CSR_SRCBIT: reg_srcbit = csr_wdata[3:0];
               smpg_pkg::CSR_MINNB:  reg_minnb = csr_wdata[3:0];
               smpg_pkg::CSR_GROW:   reg_grow = csr_wdata[0];
               default:    ;
            endcase
         end
         if (start && !busy) expected_rsps.push_back(frame_step(req_item));
      end
   end

   task automatic push_item(logic [1:0] op, int unsigned idx, int unsigned word);
      smpg_pkg::req_type it;
      it.operation = op;
      it.pixel_index = idx[15:0];
      it.quality_word = word[15:0];
      if (op == smpg_pkg::OP_LOAD) written[idx[15:0]] = 1;
      pending_items.push_back(it);
   endtask

   task automatic drain();
      wait (pending_items.size() == 0 && !start && expected_rsps.size() == 0);
      repeat (30) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, int unsigned val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[smpg_pkg::CsrDataWidth-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // word with the source flag set more often than not
   function automatic int unsigned flag_word(int unsigned sb);
      logic [15:0] v;
      v = 16'($urandom);
      v[sb] = ($urandom_range(0, 99) < 60);
      return 32'(v);
   endfunction

   // one setting: write registers, fill the frame in use, then random items
   task automatic run_setting(int unsigned wr, int unsigned hr, int unsigned sb,
                              int unsigned mn, int unsigned gm, int unsigned n_items);
      int unsigned area, roll, idx;
      csr_write(smpg_pkg::CSR_WIDTH, wr);
      csr_write(smpg_pkg::CSR_HEIGHT, hr);
      csr_write(smpg_pkg::CSR_SRCBIT, sb);
      csr_write(smpg_pkg::CSR_MINNB, mn);
      csr_write(smpg_pkg::CSR_GROW, gm);
      area = clamp_dim(wr[8:0]) * clamp_dim(hr[8:0]);
      for (int k = 0; k < area; k++) push_item(smpg_pkg::OP_LOAD, k, flag_word(sb));
      push_item(smpg_pkg::OP_PROCESS, $urandom, $urandom);
      for (int n = 0; n < n_items; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            push_item(smpg_pkg::OP_LOAD, $urandom_range(0, area - 1), flag_word(sb));
         end else if (roll < 47) begin
            push_item(smpg_pkg::OP_LOAD, $urandom_range(0, 65535), $urandom);
         end else if (roll < 82) begin
            idx = $urandom_range(0, 65535);
            if (!written[idx]) idx = $urandom_range(0, area - 1);
            push_item(smpg_pkg::OP_READ, idx, $urandom);
         end else if (roll < 93) begin
            push_item(smpg_pkg::OP_PROCESS, $urandom, $urandom);
         end else begin
            push_item(2'd3, $urandom, $urandom);
         end
      end
      // read back the start of the frame in use after a final pass
      push_item(smpg_pkg::OP_PROCESS, $urandom, $urandom);
      for (int k = 0; k < area && k < 16; k++) push_item(smpg_pkg::OP_READ, k, $urandom);
      drain();
   endtask

   // stimulus
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: single pixel frame, storage extremes, unused operation
      csr_write(smpg_pkg::CSR_WIDTH, 0);
      csr_write(smpg_pkg::CSR_HEIGHT, 0);
      csr_write(smpg_pkg::CSR_SRCBIT, 0);
      csr_write(smpg_pkg::CSR_MINNB, 0);
      csr_write(smpg_pkg::CSR_GROW, 0);
      push_item(smpg_pkg::OP_LOAD, 0, 16'h0001);
      push_item(smpg_pkg::OP_LOAD, 65535, 16'hFFFF);
      push_item(smpg_pkg::OP_LOAD, 16'hAAAA, 16'h5555);
      push_item(smpg_pkg::OP_LOAD, 16'h5555, 16'hAAAA);
      push_item(smpg_pkg::OP_READ, 65535, 16'hFFFF);
      push_item(smpg_pkg::OP_READ, 16'hAAAA, 16'h0);
      push_item(smpg_pkg::OP_READ, 16'h5555, 16'h0);
      push_item(smpg_pkg::OP_PROCESS, 16'hFFFF, 16'hFFFF);
      push_item(smpg_pkg::OP_READ, 0, 16'h0);
      push_item(2'd3, 16'hFFFF, 16'hFFFF);
      push_item(2'd3, 0, 0);
      push_item(smpg_pkg::OP_LOAD, 0, 16'h0000);
      push_item(smpg_pkg::OP_PROCESS, 0, 0);
      push_item(smpg_pkg::OP_READ, 0, 0);
      drain();

      // min count above nine on a single pixel clears it
      csr_write(smpg_pkg::CSR_MINNB, 15);
      push_item(smpg_pkg::OP_LOAD, 0, 16'hFFFF);
      push_item(smpg_pkg::OP_PROCESS, 0, 0);
      push_item(smpg_pkg::OP_READ, 0, 0);
      drain();

      run_setting(3, 3, 15, 9, 1, 20);
      run_setting(4, 4, 15, 1, 0, 20);
      steady = 1;
      run_setting(8, 6, 11, 4, 0, 40);
      steady = 0;
      run_setting(511, 1, 5, 10, 1, 16);
      run_setting(1, 6, 3, 2, 1, 12);
      run_setting(5, 4, 1, 2, 1, 10);

      if (errors == 0) begin
         $display("source_mask_prune_and_grow_tb: clean");
      end else begin
         $display("source_mask_prune_and_grow_tb: errors");
      end
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("source_mask_prune_and_grow_tb: errors");
      $finish;
   end

endmodule
`default_nettype wire
